// ===== sv/yuv420_crop_rotate_mapper_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the planar 4:2:0 crop and rotate mapper
// Each macro expects signals clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef YUV420_CROP_ROTATE_MAPPER_UNIT_ASSERT_SVH
`define YUV420_CROP_ROTATE_MAPPER_UNIT_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the cycle after the antecedent.
`define CRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The condition must never be true outside reset.
`define CRM_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");

`else

`define CRM_ASSERT_NEXT(label, ante, cons)
`define CRM_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== sv/crm_pkg.sv =====
// ----------------------------------------------------------------------------
// crm_pkg
// Types, codes and helper functions shared by the crop and rotate mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crm_pkg;

	localparam int DIM_W   = 13;
	localparam int MAX_DIM = 4096;
	localparam int OFF_W   = 24;
	localparam int PIX_W   = 8;
	localparam int ADDR_W  = 3;

	typedef enum logic [1:0] {
		MODE_CROP     = 2'd0,
		MODE_ROT90    = 2'd1,
		MODE_ROT270_M = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_MODE        = 3'd0,
		REG_SRC_WIDTH   = 3'd1,
		REG_SRC_HEIGHT  = 3'd2,
		REG_CROP_WIDTH  = 3'd3,
		REG_CROP_HEIGHT = 3'd4
	} reg_idx_t;

	localparam logic [1:0] PLANE_LUMA     = 2'd0;
	localparam logic [1:0] PLANE_CHROMA_A = 2'd1;
	localparam logic [1:0] PLANE_CHROMA_B = 2'd2;

	// Effective luma sizes after clamping.
	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] cw;
		logic [DIM_W-1:0] ch;
	} dims_t;

	// Sizes of the plane that the current byte belongs to.
	typedef struct packed {
		logic [DIM_W-1:0] pw;
		logic [DIM_W-1:0] ph;
		logic [DIM_W-1:0] kw;
		logic [DIM_W-1:0] kh;
	} plane_dims_t;

	typedef struct packed {
		logic [1:0]       plane;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
	} pos_t;

	function automatic logic [DIM_W-1:0] fix_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
		r[0] = 1'b0;
		if (r < DIM_W'(2)) r = DIM_W'(2);
		return r;
	endfunction

	function automatic plane_dims_t plane_dims(input dims_t d, input logic chroma);
		plane_dims_t p;
		if (chroma) begin
			p.pw = d.sw >> 1;
			p.ph = d.sh >> 1;
			p.kw = d.cw >> 1;
			p.kh = d.ch >> 1;
		end else begin
			p.pw = d.sw;
			p.ph = d.sh;
			p.kw = d.cw;
			p.kh = d.ch;
		end
		return p;
	endfunction

endpackage

// ===== sv/crm_cfg.sv =====
// ----------------------------------------------------------------------------
// crm_cfg
// Configuration registers and the clamped sizes derived from them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crm_cfg import crm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [DIM_W-1:0]  cfg_wdata,
	output mode_t             mode,
	output dims_t             dims
);

	logic [1:0]       mode_q;
	logic [DIM_W-1:0] src_w_q;
	logic [DIM_W-1:0] src_h_q;
	logic [DIM_W-1:0] crop_w_q;
	logic [DIM_W-1:0] crop_h_q;
	logic [DIM_W-1:0] fcw;
	logic [DIM_W-1:0] fch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CROP;
			src_w_q  <= DIM_W'(640);
			src_h_q  <= DIM_W'(480);
			crop_w_q <= DIM_W'(640);
			crop_h_q <= DIM_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODE:        mode_q   <= cfg_wdata[1:0];
				REG_SRC_WIDTH:   src_w_q  <= cfg_wdata;
				REG_SRC_HEIGHT:  src_h_q  <= cfg_wdata;
				REG_CROP_WIDTH:  crop_w_q <= cfg_wdata;
				REG_CROP_HEIGHT: crop_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		mode    = mode_t'(mode_q);
		dims.sw = fix_dim(src_w_q);
		dims.sh = fix_dim(src_h_q);
		fcw     = fix_dim(crop_w_q);
		fch     = fix_dim(crop_h_q);
		dims.cw = (fcw < dims.sw) ? fcw : dims.sw;
		dims.ch = (fch < dims.sh) ? fch : dims.sh;
	end

endmodule

// ===== sv/crm_pos.sv =====
// ----------------------------------------------------------------------------
// crm_pos
// Column, row and plane counters and the input register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "yuv420_crop_rotate_mapper_unit_assert.svh"

module crm_pos import crm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_start,
	input  dims_t            dims,
	input  logic             adv_s1,
	output logic             valid_s1,
	output pos_t             pos_s1,
	output logic [PIX_W-1:0] pixel_s1
);

	pos_t        cnt_q;
	pos_t        cur;
	pos_t        nxt;
	plane_dims_t pd;
	logic        accept;

	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cur = frame_start ? '0 : cnt_q;
		pd  = plane_dims(dims, cur.plane != PLANE_LUMA);
		nxt = cur;
		if (({1'b0, cur.col} + 1'b1) >= {1'b0, pd.pw}) begin
			nxt.col = '0;
			if (({1'b0, cur.row} + 1'b1) >= {1'b0, pd.ph}) begin
				nxt.row   = '0;
				nxt.plane = (cur.plane >= PLANE_CHROMA_B) ? PLANE_LUMA : cur.plane + 2'd1;
			end else begin
				nxt.row = cur.row + 1'b1;
			end
		end else begin
			nxt.col = cur.col + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) cnt_q <= nxt;
			if (in_ready) valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1   <= cur;
			pixel_s1 <= pixel;
		end
	end

	// The plane counter wraps after the second chroma plane.
	`CRM_ASSERT_NEVER(a_plane_range, cnt_q.plane == 2'd3)
	// A beat marked as frame start always enters at the origin.
	`CRM_ASSERT_NEXT(a_frame_origin, accept && frame_start, pos_s1 == '0)

endmodule

// ===== sv/crm_map.sv =====
// ----------------------------------------------------------------------------
// crm_map
// Window test, output offset computation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "yuv420_crop_rotate_mapper_unit_assert.svh"

module crm_map import crm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  pos_t              pos_s1,
	input  logic [PIX_W-1:0]  pixel_s1,
	input  dims_t             dims,
	input  mode_t             mode,
	output logic              adv_s1,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_plane,
	output logic [OFF_W-1:0]  out_offset,
	output logic [PIX_W-1:0]  out_value
);

	plane_dims_t        pd;
	logic [DIM_W-1:0]   xs;
	logic [DIM_W-1:0]   ys;
	logic [DIM_W-1:0]   mul_a;
	logic [DIM_W-1:0]   mul_b;
	logic [DIM_W-1:0]   add_c;
	logic [2*DIM_W-1:0] sum;
	logic [1:0]         oplane;
	logic               hit;

	assign adv_s1 = !out_valid || out_ready;

	// All three mappings reduce to a * b + c with one multiplier.
	always_comb begin
		pd    = plane_dims(dims, pos_s1.plane != PLANE_LUMA);
		xs    = pd.pw - pd.kw;
		ys    = pd.ph - pd.kh;
		hit   = 1'b0;
		mul_a = '0;
		mul_b = '0;
		add_c = '0;
		unique case (mode)
			MODE_CROP: begin
				hit   = pos_s1.row >= ys && pos_s1.row < pd.ph && pos_s1.col < pd.kw;
				mul_a = pos_s1.row - ys;
				mul_b = pd.kw;
				add_c = pos_s1.col;
			end
			MODE_ROT90: begin
				hit   = pos_s1.row >= ys && pos_s1.row < pd.ph && pos_s1.col < pd.kw;
				mul_a = pos_s1.col;
				mul_b = pd.kh;
				add_c = pd.kh - 1'b1 - (pos_s1.row - ys);
			end
			MODE_ROT270_M: begin
				hit   = pos_s1.row < pd.kh && pos_s1.col >= xs && pos_s1.col < pd.pw;
				mul_a = pd.kw - 1'b1 - (pos_s1.col - xs);
				mul_b = pd.kh;
				add_c = pd.kh - 1'b1 - pos_s1.row;
			end
			MODE_NONE: hit = 1'b0;
			default: hit = 1'b0;
		endcase
		sum = (2*DIM_W)'(mul_a) * (2*DIM_W)'(mul_b) + (2*DIM_W)'(add_c);
		unique case (pos_s1.plane)
			PLANE_LUMA:     oplane = PLANE_LUMA;
			PLANE_CHROMA_A: oplane = PLANE_CHROMA_B;
			default:        oplane = PLANE_CHROMA_A;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && hit) begin
			out_plane  <= oplane;
			out_offset <= sum[OFF_W-1:0];
			out_value  <= pixel_s1;
		end
	end

	// With output disabled a beat leaving the first stage never becomes a result.
	`CRM_ASSERT_NEXT(a_mode_none, valid_s1 && adv_s1 && mode == MODE_NONE, !out_valid)
	// Plane code three is never produced.
	`CRM_ASSERT_NEVER(a_plane_code, out_valid && out_plane == 2'd3)

endmodule

// ===== sv/yuv420_crop_rotate_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// yuv420_crop_rotate_mapper_unit
// Places the bytes of a planar 4:2:0 frame into a cropped and rotated layout.
// ----------------------------------------------------------------------------
// Accepts one byte per clock cycle with no bubbles while the output is not
// stalled, since the position counters advance in the cycle a beat is taken.
// Inside, the first stage registers the byte with its column, row and plane,
// the second runs the window test and the single 13 by 13 bit multiply that
// forms the offset, and holds a result in the output register. Bytes outside
// the crop window, and every byte in mode 3, leave no result. Chroma planes
// are swapped on output. Write the configuration only while no beat is in
// flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv420_crop_rotate_mapper_unit import crm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [DIM_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_plane,
	output logic [OFF_W-1:0]  out_offset,
	output logic [PIX_W-1:0]  out_value
);

	mode_t            mode;
	dims_t            dims;
	logic             adv_s1;
	logic             valid_s1;
	pos_t             pos_s1;
	logic [PIX_W-1:0] pixel_s1;

	crm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.mode      (mode),
		.dims      (dims)
	);

	crm_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.frame_start (frame_start),
		.dims        (dims),
		.adv_s1      (adv_s1),
		.valid_s1    (valid_s1),
		.pos_s1      (pos_s1),
		.pixel_s1    (pixel_s1)
	);

	crm_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.pos_s1     (pos_s1),
		.pixel_s1   (pixel_s1),
		.dims       (dims),
		.mode       (mode),
		.adv_s1     (adv_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_plane  (out_plane),
		.out_offset (out_offset),
		.out_value  (out_value)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Byte stream test for the planar 4:2:0 crop and rotate mapper. A placement
// checker tracks column, row and plane like the block does and predicts the
// plane, offset and value of every byte that falls in the crop window. Frames
// are sent with random sizes, modes and content under random stalls on both
// sides. Each result beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import crm_pkg::*;

typedef struct packed {
	logic [1:0]       plane;
	logic [OFF_W-1:0] offset;
	logic [PIX_W-1:0] value;
} placement_t;

class placement_checker;
	mode_t            cur_mode;
	logic [DIM_W-1:0] reg_sw, reg_sh, reg_cw, reg_ch;
	logic [DIM_W-1:0] col_pos, row_pos;
	logic [1:0]       plane_pos;
	placement_t       pending[$];
	int               mismatches;

	function new();
		cur_mode   = MODE_CROP;
		reg_sw     = 13'd640;
		reg_sh     = 13'd480;
		reg_cw     = 13'd640;
		reg_ch     = 13'd480;
		col_pos    = '0;
		row_pos    = '0;
		plane_pos  = '0;
		mismatches = 0;
	endfunction

	function int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		int unsigned r;
		r = v;
		if (r > MAX_DIM) r = MAX_DIM;
		r = r & ~32'd1;
		if (r < 2) r = 2;
		return r;
	endfunction

	function void set_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
		case (idx)
			REG_MODE:        cur_mode = mode_t'(val[1:0]);
			REG_SRC_WIDTH:   reg_sw = val;
			REG_SRC_HEIGHT:  reg_sh = val;
			REG_CROP_WIDTH:  reg_cw = val;
			REG_CROP_HEIGHT: reg_ch = val;
			default: ;
		endcase
	endfunction

	// Number of bytes in one whole frame at the current sizes.
	function int unsigned frame_bytes();
		int unsigned sw, sh;
		sw = clamp_dim(reg_sw);
		sh = clamp_dim(reg_sh);
		return sw * sh + 2 * (sw / 2) * (sh / 2);
	endfunction

	function void note_byte(input logic [PIX_W-1:0] pix, input logic fs);
		int unsigned sw, sh, cw, ch, pw, ph, kw, kh, xs, ys, r, c, off;
		bit          hit;
		placement_t  p;
		sw = clamp_dim(reg_sw);
		sh = clamp_dim(reg_sh);
		cw = clamp_dim(reg_cw);
		ch = clamp_dim(reg_ch);
		if (cw > sw) cw = sw;
		if (ch > sh) ch = sh;
		if (fs) begin
			col_pos   = '0;
			row_pos   = '0;
			plane_pos = '0;
		end
		if (plane_pos == 2'd0) begin
			pw = sw; ph = sh; kw = cw; kh = ch;
		end else begin
			pw = sw / 2; ph = sh / 2; kw = cw / 2; kh = ch / 2;
		end
		xs  = pw - kw;
		ys  = ph - kh;
		r   = row_pos;
		c   = col_pos;
		hit = 1'b0;
		off = 0;
		case (cur_mode)
			MODE_CROP, MODE_ROT90: begin
				if (r >= ys && r < ph && c < kw) begin
					hit = 1'b1;
					if (cur_mode == MODE_CROP)
						off = (r - ys) * kw + c;
					else
						off = c * kh + (kh - 1 - (r - ys));
				end
			end
			MODE_ROT270_M: begin
				if (r < kh && c >= xs && c < pw) begin
					hit = 1'b1;
					off = (kw - 1 - (c - xs)) * kh + (kh - 1 - r);
				end
			end
			default: ;
		endcase
		if (hit) begin
			// The chroma planes trade places on the way out.
			if (plane_pos == 2'd0)
				p.plane = PLANE_LUMA;
			else if (plane_pos == 2'd1)
				p.plane = PLANE_CHROMA_B;
			else
				p.plane = PLANE_CHROMA_A;
			p.offset = off[OFF_W-1:0];
			p.value  = pix;
			pending.push_back(p);
		end
		if (c + 1 >= pw) begin
			col_pos = '0;
			if (r + 1 >= ph) begin
				row_pos   = '0;
				plane_pos = (plane_pos >= 2'd2) ? 2'd0 : plane_pos + 2'd1;
			end else begin
				row_pos = DIM_W'(r + 1);
			end
		end else begin
			col_pos = DIM_W'(c + 1);
		end
	endfunction

	function void check_placement(input logic [1:0] plane, input logic [OFF_W-1:0] offset,
			input logic [PIX_W-1:0] value);
		placement_t exp_p;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: plane %0d offset %0d value %0d",
					plane, offset, value);
		end else begin
			exp_p = pending.pop_front();
			if (exp_p.plane !== plane || exp_p.offset !== offset || exp_p.value !== value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected plane %0d offset %0d value %0d",
						exp_p.plane, exp_p.offset, exp_p.value,
						", got plane %0d offset %0d value %0d", plane, offset, value);
			end
		end
	endfunction
endclass

module tb_top;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [DIM_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  pixel = '0;
	logic              frame_start = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b1;
	logic [1:0]        out_plane;
	logic [OFF_W-1:0]  out_offset;
	logic [PIX_W-1:0]  out_value;

	placement_checker sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	yuv420_crop_rotate_mapper_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_plane   (out_plane),
		.out_offset  (out_offset),
		.out_value   (out_value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Receiver side; a requested hold-off is counted down here.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !roll(recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_placement(out_plane, out_offset, out_value);
			if (in_valid && in_ready)
				sb.note_byte(pixel, frame_start);
		end
	end

	task automatic send_byte(input logic [PIX_W-1:0] p, input logic fs);
		while (roll(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel       <= p;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop sending and wait for the last beat to clear the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input mode_t m, input logic [DIM_W-1:0] sw, sh, cw, ch);
		reg_idx_t         idx [5];
		logic [DIM_W-1:0] vals [5];
		idx  = '{REG_MODE, REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_CROP_WIDTH, REG_CROP_HEIGHT};
		// Upper bits of the mode word are junk the block has to ignore.
		vals = '{{11'($urandom), m}, sw, sh, cw, ch};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int budget, output int sent);
		mode_t            m;
		logic [DIM_W-1:0] sw, sh, cw, ch;
		int unsigned      fbytes, len;
		int               nframes;
		m = mode_t'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) begin
			sw = DIM_W'($urandom_range(2000, 8191));
			sh = DIM_W'($urandom_range(0, 4));
			cw = DIM_W'($urandom);
			ch = DIM_W'($urandom_range(0, 6));
		end else begin
			sw = DIM_W'($urandom_range(0, 20));
			sh = DIM_W'($urandom_range(0, 16));
			cw = DIM_W'($urandom_range(0, sw + 3));
			ch = DIM_W'($urandom_range(0, sh + 3));
		end
		configure(m, sw, sh, cw, ch);
		fbytes  = sb.frame_bytes();
		nframes = $urandom_range(1, 3);
		sent    = 0;
		for (int f = 0; f < nframes; f++) begin
			len = fbytes;
			if (roll(10)) len = $urandom_range(1, fbytes);
			for (int unsigned i = 0; i < len && sent < budget; i++) begin
				send_byte(PIX_W'($urandom), (i == 0) ? roll(90) : roll(1));
				sent++;
			end
		end
	endtask

	initial begin
		int total;
		int sent;
		int phase_no;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes and mode.
		send_byte(8'd0, 1'b1);
		send_byte(8'd255, 1'b0);
		send_byte(8'hA5, 1'b0);
		settle();

		// Largest sizes, oversized and odd values clamped; first offset is the top one.
		configure(MODE_ROT270_M, 13'd8191, 13'd4096, 13'd4097, 13'd8190);
		send_byte(8'h5A, 1'b1);
		send_byte(8'hFF, 1'b0);
		settle();
		configure(MODE_ROT90, 13'd8191, 13'd4096, 13'd4097, 13'd8190);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b0);
		settle();

		// Tiny sizes, crop above source, counters left beyond the new width,
		// a frame start in mid-frame and a wrap at frame end.
		configure(MODE_CROP, 13'd1, 13'd0, 13'd3, 13'd5);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b1);
		for (int i = 0; i < 6; i++) send_byte(PIX_W'(8'h40 + i), 1'b0);
		settle();

		configure(MODE_NONE, 13'd4, 13'd4, 13'd2, 13'd2);
		for (int i = 0; i < 4; i++) send_byte(PIX_W'($urandom), i == 0);
		settle();

		configure(MODE_ROT90, 13'd6, 13'd4, 13'd4, 13'd2);
		for (int i = 0; i < 5; i++) send_byte(PIX_W'($urandom), i == 0);
		settle();

		// Every byte lands in the window, so a long receiver hold backs the
		// block up into its input while the sender keeps offering beats.
		configure(MODE_CROP, 13'd4, 13'd4, 13'd4, 13'd4);
		hold_request = 200;
		for (int i = 0; i < 40; i++) send_byte(PIX_W'($urandom), i == 0);
		settle();

		total = 0;
		phase_no = 0;
		while (total < 1750) begin
			if (total < 583) begin
				send_idle_pct = 8;
				recv_idle_pct = 55;
			end else if (total < 1166) begin
				send_idle_pct = 55;
				recv_idle_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// One long receiver hold-off so the block backs up into its input.
			if (phase_no == 2) hold_request = 300;
			random_phase($urandom_range(60, 250), sent);
			total += sent;
			phase_no++;
			settle();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
